// ----- src/thsc_pkg.sv -----
// shared types, codes and constants for the thermostat setpoint heater control
package thsc_pkg;

    // operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_PLUS   = 2'd1;
    localparam logic [1:0] OP_MINUS  = 2'd2;

    // setpoint reset value, 21.4
    localparam logic [2:0] SP_TENS_RST   = 3'd2;
    localparam logic [3:0] SP_UNITS_RST  = 4'd1;
    localparam logic [3:0] SP_TENTHS_RST = 4'd4;

    // setpoint digit limits and step
    localparam logic [2:0] SP_TENS_MAX   = 3'd5;
    localparam logic [3:0] UNITS_MAX     = 4'd9;
    localparam logic [3:0] TENTHS_MAX    = 4'd8;
    localparam logic [3:0] TENTHS_STEP   = 4'd2;

    // adc codes per ten degrees, codes per unit digit step
    localparam logic [7:0] ADC_PER_TEN   = 8'd51;
    localparam logic [2:0] ADC_PER_UNIT  = 3'd5;
    // x / 5 as (x * 205) >> 10, exact for x up to 50
    localparam logic [7:0] UNIT_RECIP    = 8'd205;
    localparam int         UNIT_SHIFT    = 10;

    // converted temperature, passed from the converter to the top level
    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] units;
        logic [3:0] tenths;
        logic [8:0] value;
    } t_temp;

    // three digits to a value in tenths
    function automatic logic [8:0] digits_to_tenths(
        input logic [2:0] tens,
        input logic [3:0] units,
        input logic [3:0] tenths
    );
        logic [8:0] v_hund;
        logic [8:0] v_ten;
        v_hund = 9'(tens) * 9'd100;
        v_ten  = 9'(units) * 9'd10;
        return v_hund + v_ten + 9'(tenths);
    endfunction

endpackage

// ----- src/thsc_conv.sv -----
// adc code to decimal temperature digits
module thsc_conv import thsc_pkg::*; (
    input  logic [7:0] i_code,
    output t_temp      o_temp
);

    logic [2:0]  tens;
    logic [7:0]  base;
    logic [5:0]  residue;
    logic [13:0] recip_prod;
    logic [3:0]  units;
    logic [5:0]  units_x5;
    logic [2:0]  rem;

    // tens digit by threshold compares against multiples of 51
    always_comb begin
        if (i_code >= 8'(5 * 51)) begin
            tens = 3'd5;
        end else if (i_code >= 8'(4 * 51)) begin
            tens = 3'd4;
        end else if (i_code >= 8'(3 * 51)) begin
            tens = 3'd3;
        end else if (i_code >= 8'(2 * 51)) begin
            tens = 3'd2;
        end else if (i_code >= ADC_PER_TEN) begin
            tens = 3'd1;
        end else begin
            tens = 3'd0;
        end
    end

    assign base       = 8'(tens) * ADC_PER_TEN;
    assign residue    = 6'(i_code - base);
    assign recip_prod = 14'(residue) * 14'(UNIT_RECIP);
    assign units      = recip_prod[UNIT_SHIFT +: 4];
    assign units_x5   = 6'(units) * 6'(ADC_PER_UNIT);
    assign rem        = 3'(residue - units_x5);

    always_comb begin
        o_temp.tens   = tens;
        o_temp.units  = units;
        o_temp.tenths = {rem, 1'b0};
        o_temp.value  = digits_to_tenths(tens, units, {rem, 1'b0});
    end

endmodule

// ----- src/thermostat_setpoint_heater_control_top.sv -----
// top level of the on-off thermostat with a decimal setpoint
//
// usage:
//   input channel (i_in_valid / o_in_stall) carries one word: an operation
//   (sample, plus, minus) and an 8-bit adc code. output channel
//   (o_out_valid / i_out_stall) returns one word per input word: the
//   temperature digits and value (zero on button words), the setpoint digits
//   after the word, and the heater state.
//   a word passes through the input register, then the result register.
//   throughput is one word per cycle while the receiver does not stall;
//   setpoint and heater update as the word enters the result register.
//   when the receiver stalls, the result register holds and an empty input
//   register still takes one more word; after that o_in_stall rises.
//   reset (synchronous, active low) empties both registers, sets the
//   setpoint to 21.4 and turns the heater off.
//   operation code 3 returns a result and changes nothing.
module thermostat_setpoint_heater_control_top import thsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_sample,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_temp_tens,
    output logic [3:0] o_temp_units,
    output logic [3:0] o_temp_tenths,
    output logic [8:0] o_temp_value,
    output logic [2:0] o_set_tens_out,
    output logic [3:0] o_set_units_out,
    output logic [3:0] o_set_tenths_out,
    output logic       o_heater_out
);

    logic       r_in_valid;
    logic [1:0] r_op;
    logic [7:0] r_sample;

    logic [2:0] r_set_tens,   n_set_tens;
    logic [3:0] r_set_units,  n_set_units;
    logic [3:0] r_set_tenths, n_set_tenths;
    logic       r_heater,     n_heater;

    logic       r_out_valid;
    t_temp      r_temp,       n_temp;

    t_temp      conv_temp;
    logic [8:0] target;
    logic       advance;
    logic       load_in;

    // word moves from input register to result register
    assign advance = r_in_valid && (!r_out_valid || !i_out_stall);
    assign load_in = !r_in_valid || advance;
    assign o_in_stall = !load_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load_in) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in && i_in_valid) begin
            r_op     <= i_operation;
            r_sample <= i_sample;
        end
    end

    thsc_conv u_conv (
        .i_code (r_sample),
        .o_temp (conv_temp)
    );

    assign target = digits_to_tenths(r_set_tens, r_set_units, r_set_tenths);

    always_comb begin
        n_set_tens   = r_set_tens;
        n_set_units  = r_set_units;
        n_set_tenths = r_set_tenths;
        n_heater     = r_heater;
        n_temp       = '0;
        case (r_op)
            OP_SAMPLE: begin
                n_temp   = conv_temp;
                n_heater = conv_temp.value < target;
            end
            OP_PLUS: begin
                if (r_set_tens < SP_TENS_MAX) begin
                    if (r_set_tenths != TENTHS_MAX) begin
                        n_set_tenths = r_set_tenths + TENTHS_STEP;
                    end else if (r_set_units != UNITS_MAX) begin
                        n_set_tenths = '0;
                        n_set_units  = r_set_units + 4'd1;
                    end else begin
                        n_set_tenths = '0;
                        n_set_units  = '0;
                        n_set_tens   = r_set_tens + 3'd1;
                    end
                end
            end
            OP_MINUS: begin
                if (r_set_tenths != '0) begin
                    n_set_tenths = r_set_tenths - TENTHS_STEP;
                end else if (r_set_units != '0) begin
                    n_set_tenths = TENTHS_MAX;
                    n_set_units  = r_set_units - 4'd1;
                end else if (r_set_tens != '0) begin
                    n_set_tenths = TENTHS_MAX;
                    n_set_units  = UNITS_MAX;
                    n_set_tens   = r_set_tens - 3'd1;
                end
            end
            default: begin
                n_temp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_tens   <= SP_TENS_RST;
            r_set_units  <= SP_UNITS_RST;
            r_set_tenths <= SP_TENTHS_RST;
            r_heater     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (advance) begin
                r_set_tens   <= n_set_tens;
                r_set_units  <= n_set_units;
                r_set_tenths <= n_set_tenths;
                r_heater     <= n_heater;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_temp <= n_temp;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_temp_tens      = r_temp.tens;
    assign o_temp_units     = r_temp.units;
    assign o_temp_tenths    = r_temp.tenths;
    assign o_temp_value     = r_temp.value;
    // setpoint and heater registers already hold the state after the word
    assign o_set_tens_out   = r_set_tens;
    assign o_set_units_out  = r_set_units;
    assign o_set_tenths_out = r_set_tenths;
    assign o_heater_out     = r_heater;

    // setpoint stays within 00.0 to 50.0 and on even tenths
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_set_tens < SP_TENS_MAX) ||
        (r_set_tens == SP_TENS_MAX && r_set_units == '0 && r_set_tenths == '0))
        else $error("setpoint out of range");

    a_sp_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_set_tenths[0] && r_set_tenths <= TENTHS_MAX && r_set_units <= UNITS_MAX)
        else $error("setpoint digit invalid");

    // heater only changes on a sample word
    a_heater_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_op != OP_SAMPLE) |=> $stable(r_heater))
        else $error("heater changed on a button word");

    // value agrees with its digits
    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_temp.value ==
            digits_to_tenths(r_temp.tens, r_temp.units, r_temp.tenths)))
        else $error("temperature value mismatch");

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the thermostat setpoint heater control top level
`timescale 1ns / 100ps

module testbench;
    import thsc_pkg::*;

    localparam logic [1:0] OP_NOOP    = 2'd3;
    localparam int         WATCHDOG   = 3000;
    localparam int         DRAIN_WAIT = 10;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] code;
    } t_word;

    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] units;
        logic [3:0] tenths;
        logic [8:0] value;
        logic [2:0] sp_tens;
        logic [3:0] sp_units;
        logic [3:0] sp_tenths;
        logic       heater;
    } t_reading;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_operation = OP_SAMPLE;
    logic [7:0] i_sample    = 8'd0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [2:0] o_temp_tens;
    logic [3:0] o_temp_units;
    logic [3:0] o_temp_tenths;
    logic [8:0] o_temp_value;
    logic [2:0] o_set_tens_out;
    logic [3:0] o_set_units_out;
    logic [3:0] o_set_tenths_out;
    logic       o_heater_out;

    t_word    words_to_send[$];
    t_reading readings_due[$];

    // own copy of the setpoint and heater
    logic [2:0] sp_tens   = SP_TENS_RST;
    logic [3:0] sp_units  = SP_UNITS_RST;
    logic [3:0] sp_tenths = SP_TENTHS_RST;
    logic       heater_on = 1'b0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int err_count     = 0;
    int quiet_cycles  = 0;

    thermostat_setpoint_heater_control_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_temp_tens      (o_temp_tens),
        .o_temp_units     (o_temp_units),
        .o_temp_tenths    (o_temp_tenths),
        .o_temp_value     (o_temp_value),
        .o_set_tens_out   (o_set_tens_out),
        .o_set_units_out  (o_set_units_out),
        .o_set_tenths_out (o_set_tenths_out),
        .o_heater_out     (o_heater_out)
    );

    always #1 i_clk = ~i_clk;

    // thermostat behavior for one accepted word
    task automatic predict_reading(input t_word w);
        t_reading r;
        int       residue;
        int       target;
        r = '0;
        case (w.op)
            OP_SAMPLE: begin
                residue  = int'(w.code) % 51;
                r.tens   = 3'(int'(w.code) / 51);
                r.units  = 4'(residue / 5);
                r.tenths = 4'((residue % 5) * 2);
                r.value  = 9'(int'(r.tens) * 100 + int'(r.units) * 10 + int'(r.tenths));
                target   = int'(sp_tens) * 100 + int'(sp_units) * 10 + int'(sp_tenths);
                heater_on = (int'(r.value) < target);
            end
            OP_PLUS: begin
                // saturates at 50.0
                if (sp_tens < SP_TENS_MAX) begin
                    if (sp_tenths != TENTHS_MAX) begin
                        sp_tenths = sp_tenths + TENTHS_STEP;
                    end else if (sp_units != UNITS_MAX) begin
                        sp_tenths = 4'd0;
                        sp_units  = sp_units + 4'd1;
                    end else begin
                        sp_tenths = 4'd0;
                        sp_units  = 4'd0;
                        sp_tens   = sp_tens + 3'd1;
                    end
                end
            end
            OP_MINUS: begin
                if (sp_tenths != 4'd0) begin
                    sp_tenths = sp_tenths - TENTHS_STEP;
                end else if (sp_units != 4'd0) begin
                    sp_tenths = TENTHS_MAX;
                    sp_units  = sp_units - 4'd1;
                end else if (sp_tens != 3'd0) begin
                    sp_tenths = TENTHS_MAX;
                    sp_units  = UNITS_MAX;
                    sp_tens   = sp_tens - 3'd1;
                end
            end
            default: begin
            end
        endcase
        r.sp_tens   = sp_tens;
        r.sp_units  = sp_units;
        r.sp_tenths = sp_tenths;
        r.heater    = heater_on;
        readings_due.push_back(r);
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
            err_count++;
        end
    endtask

    // driver: payload holds while stalled
    always @(posedge i_clk) begin : driver
        t_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                w.op   = i_operation;
                w.code = i_sample;
                predict_reading(w);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = words_to_send.pop_front();
                    i_operation <= w.op;
                    i_sample    <= w.code;
                    i_in_valid  <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each accepted word with the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_reading r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (readings_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got temp %0d",
                             $time, o_temp_value);
                    err_count++;
                end else begin
                    r = readings_due.pop_front();
                    check_field("temp_tens",      r.tens,      o_temp_tens);
                    check_field("temp_units",     r.units,     o_temp_units);
                    check_field("temp_tenths",    r.tenths,    o_temp_tenths);
                    check_field("temp_value",     r.value,     o_temp_value);
                    check_field("set_tens_out",   r.sp_tens,   o_set_tens_out);
                    check_field("set_units_out",  r.sp_units,  o_set_units_out);
                    check_field("set_tenths_out", r.sp_tenths, o_set_tenths_out);
                    check_field("heater_out",     r.heater,    o_heater_out);
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG) begin
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_word(input logic [1:0] op, input logic [7:0] code);
        t_word w;
        w.op   = op;
        w.code = code;
        words_to_send.push_back(w);
    endtask

    task automatic push_run(input logic [1:0] op, input int len);
        for (int i = 0; i < len; i++) begin
            push_word(op, 8'($urandom));
        end
    endtask

    // mostly samples and button runs, some unused codes as noise
    task automatic queue_random(input int n);
        int queued;
        int kind;
        int len;
        queued = 0;
        while (queued < n) begin
            kind = $urandom_range(31);
            if (kind <= 13) begin
                push_word(OP_SAMPLE, 8'($urandom));
                len = 1;
            end else if (kind <= 19) begin
                len = $urandom_range(1, 40);
                push_run(OP_PLUS, len);
            end else if (kind <= 25) begin
                len = $urandom_range(1, 40);
                push_run(OP_MINUS, len);
            end else if (kind == 26) begin
                len = $urandom_range(100, 160);
                push_run(OP_PLUS, len);
            end else if (kind == 27) begin
                len = $urandom_range(100, 260);
                push_run(OP_MINUS, len);
            end else begin
                push_word(OP_NOOP, 8'($urandom));
                len = 1;
            end
            queued += len;
        end
    endtask

    // checked between edges so the driver and monitor updates have settled
    task automatic wait_for_drain();
        while (words_to_send.size() != 0 || readings_due.size() != 0 || i_in_valid) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 74, 0, 22};
        stall_tab = '{0, 0, 74, 22};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 4; p++) begin
            @(negedge i_clk);
            send_idle_pct = idle_tab[p];
            stall_pct     = stall_tab[p];
            if (p == 0) begin
                // digit extremes, the residue of 50 and the heater edge at 21.4
                push_word(OP_SAMPLE, 8'd0);
                push_word(OP_SAMPLE, 8'd255);
                push_word(OP_SAMPLE, 8'd50);
                push_word(OP_SAMPLE, 8'd51);
                push_word(OP_SAMPLE, 8'd101);
                push_word(OP_SAMPLE, 8'd109);
                push_word(OP_SAMPLE, 8'd108);
                push_word(OP_PLUS,   8'hff);
                push_word(OP_NOOP,   8'd255);
                push_word(OP_MINUS,  8'h00);
                push_word(OP_MINUS,  8'haa);
                push_word(OP_SAMPLE, 8'd109);
                push_word(OP_SAMPLE, 8'd107);
                push_word(OP_NOOP,   8'd0);
                push_word(OP_PLUS,   8'haa);
                push_word(OP_MINUS,  8'h55);
                push_word(OP_SAMPLE, 8'd204);
                push_word(OP_SAMPLE, 8'd203);
                push_word(OP_SAMPLE, 8'd153);
                push_word(OP_SAMPLE, 8'd152);
                push_word(OP_SAMPLE, 8'd1);
                push_word(OP_SAMPLE, 8'd2);
                push_word(OP_SAMPLE, 8'd49);
                // sweep the setpoint into the top clamp, then the bottom clamp
                push_run(OP_PLUS, 145);
                push_word(OP_SAMPLE, 8'd255);
                push_run(OP_MINUS, 260);
                push_word(OP_SAMPLE, 8'd0);
                queue_random(100);
            end else begin
                queue_random(300);
            end
            // sender holds off until every result of the phase is back
            wait_for_drain();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/thsc_pkg.sv
src/thsc_conv.sv
src/thermostat_setpoint_heater_control_top.sv
verif/testbench.sv
